@@ rtl/core/ppsch_pkg.sv @@
// Shared types and codes for the preemptive priority scheduler.
// No dependencies; imported by every module of the block.
package ppsch_pkg;

  // Request operation codes.
  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Result kind codes.
  localparam logic [1:0] KIND_ACCEPT = 2'd0;
  localparam logic [1:0] KIND_RUN    = 2'd1;
  localparam logic [1:0] KIND_IDLE   = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_REPORT
  } state_t;

  // One table entry apart from its pid, whose width is a parameter.
  typedef struct packed {
    logic [15:0] remaining;
    logic [15:0] burst;
    logic [7:0]  priority_lvl;
    logic [31:0] arrival;
    logic        started;
    logic [31:0] first_start;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic rd_en;
    logic update;
    logic report;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
  } dp_sts_t;

endpackage

@@ rtl/core/ppsch_ctrl.sv @@
// Scheduler sequencing state machine: accept, table scan, drain, update, report.
// Depends on ppsch_pkg for the state type and the command/status structs.
module ppsch_ctrl import ppsch_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd,
  output logic     busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN:  state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_REPORT;
      ST_REPORT: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE:   cmd.load   = start;
      ST_SCAN:   cmd.rd_en  = 1'b1;
      ST_DRAIN:  cmd        = '0;
      ST_UPDATE: cmd.update = 1'b1;
      ST_REPORT: cmd.report = 1'b1;
      default:   cmd        = '0;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

@@ rtl/core/ppsch_dp.sv @@
// Scheduler datapath: entry table memory, valid bits, scan compare, clock and results.
// Depends on ppsch_pkg; driven by ppsch_ctrl through ctl_cmd_t.
module ppsch_dp import ppsch_pkg::*; #(
  parameter int SLOTS    = 16,
  parameter int PID_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ctl_cmd_t    cmd,
  output dp_sts_t     sts,
  input  logic        in_op,
  input  logic [7:0]  in_pid,
  input  logic [15:0] in_burst,
  input  logic [7:0]  in_priority_req,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_run_pid,
  output logic        out_finished,
  output logic [31:0] out_now,
  output logic [31:0] out_turnaround,
  output logic [31:0] out_waiting,
  output logic [31:0] out_response
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  // Table storage.
  entry_t              mem_ent [SLOTS];
  logic [PID_BITS-1:0] mem_pid [SLOTS];
  logic [SLOTS-1:0]    valid_r;

  // Latched request.
  logic                op_r;
  logic [PID_BITS-1:0] pid_r;
  logic [15:0]         burst_r;
  logic [7:0]          prio_r;

  // Scan pipeline.
  logic [IDX_W-1:0]    cnt_r;
  logic                cmp_vld_r;
  logic                cmp_live_r;
  logic [IDX_W-1:0]    cmp_idx_r;
  entry_t              rd_ent_r;
  logic [PID_BITS-1:0] rd_pid_r;

  // Scan outcome.
  logic                best_found_r;
  logic [IDX_W-1:0]    best_idx_r;
  entry_t              best_ent_r;
  logic [PID_BITS-1:0] best_pid_r;
  logic                free_found_r;
  logic [IDX_W-1:0]    free_idx_r;

  // Clock; now_p1_r always holds clock_r + 1.
  logic [31:0]         clock_r;
  logic [31:0]         now_p1_r;

  // Update-stage results.
  logic [1:0]          kind_r;
  logic [PID_BITS-1:0] run_pid_r;
  logic                fin_r;
  logic [31:0]         ta_r;
  logic [31:0]         rt_r;
  logic [15:0]         fin_burst_r;

  // Output registers.
  logic                out_valid_r;
  logic [1:0]          out_kind_r;
  logic [7:0]          out_run_pid_r;
  logic                out_finished_r;
  logic [31:0]         out_now_r;
  logic [31:0]         out_turnaround_r;
  logic [31:0]         out_waiting_r;
  logic [31:0]         out_response_r;

  logic [PID_BITS+7:0] in_pid_ext;
  logic [PID_BITS+7:0] run_pid_ext;
  logic                cand_better;
  logic                sel_fin;
  entry_t              upd_ent;
  entry_t              new_ent;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_idx;
  entry_t              wr_ent;
  logic [PID_BITS-1:0] wr_pid;

  assign sts.scan_last = (cnt_r == LAST_IDX);

  // Pid is kept to PID_BITS bits in the table and shown as 8 bits at the ports.
  assign in_pid_ext  = {{PID_BITS{1'b0}}, in_pid};
  assign run_pid_ext = {8'h00, run_pid_r};

  // A later slot replaces the current best only when strictly better.
  always_comb begin
    if (rd_ent_r.priority_lvl != best_ent_r.priority_lvl) begin
      cand_better = rd_ent_r.priority_lvl < best_ent_r.priority_lvl;
    end else if (rd_ent_r.remaining != best_ent_r.remaining) begin
      cand_better = rd_ent_r.remaining < best_ent_r.remaining;
    end else if (rd_ent_r.arrival != best_ent_r.arrival) begin
      cand_better = rd_ent_r.arrival < best_ent_r.arrival;
    end else begin
      cand_better = rd_pid_r < best_pid_r;
    end
  end

  assign sel_fin = (best_ent_r.remaining <= 16'd1);

  always_comb begin
    upd_ent         = best_ent_r;
    upd_ent.started = 1'b1;
    if (!best_ent_r.started) upd_ent.first_start = clock_r;
    upd_ent.remaining = sel_fin ? 16'd0 : best_ent_r.remaining - 16'd1;
  end

  always_comb begin
    new_ent.remaining    = burst_r;
    new_ent.burst        = burst_r;
    new_ent.priority_lvl = prio_r;
    new_ent.arrival      = clock_r;
    new_ent.started      = 1'b0;
    new_ent.first_start  = '0;
  end

  always_comb begin
    if (op_r == OP_ARRIVE) begin
      wr_en  = cmd.update && free_found_r;
      wr_idx = free_idx_r;
      wr_ent = new_ent;
      wr_pid = pid_r;
    end else begin
      wr_en  = cmd.update && best_found_r;
      wr_idx = best_idx_r;
      wr_ent = upd_ent;
      wr_pid = best_pid_r;
    end
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_ent[wr_idx] <= wr_ent;
      mem_pid[wr_idx] <= wr_pid;
    end
    if (cmd.rd_en) begin
      rd_ent_r <= mem_ent[cnt_r];
      rd_pid_r <= mem_pid[cnt_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      pid_r   <= in_pid_ext[PID_BITS-1:0];
      burst_r <= in_burst;
      prio_r  <= in_priority_req;
    end
    if (cmd.rd_en) begin
      cmp_idx_r <= cnt_r;
    end
    if (cmp_vld_r && cmp_live_r && (!best_found_r || cand_better)) begin
      best_idx_r <= cmp_idx_r;
      best_ent_r <= rd_ent_r;
      best_pid_r <= rd_pid_r;
    end
    if (cmp_vld_r && !cmp_live_r && !free_found_r) begin
      free_idx_r <= cmp_idx_r;
    end
    if (cmd.update) begin
      fin_r       <= 1'b0;
      ta_r        <= '0;
      rt_r        <= '0;
      fin_burst_r <= best_ent_r.burst;
      if (op_r == OP_ARRIVE) begin
        kind_r    <= free_found_r ? KIND_ACCEPT : KIND_REJECT;
        run_pid_r <= pid_r;
      end else if (best_found_r) begin
        kind_r    <= KIND_RUN;
        run_pid_r <= best_pid_r;
        if (sel_fin) begin
          fin_r <= 1'b1;
          ta_r  <= now_p1_r - best_ent_r.arrival;
          rt_r  <= upd_ent.first_start - best_ent_r.arrival;
        end
      end else begin
        kind_r    <= KIND_IDLE;
        run_pid_r <= '0;
      end
    end
    if (cmd.report) begin
      out_kind_r       <= kind_r;
      out_run_pid_r    <= run_pid_ext[7:0];
      out_finished_r   <= fin_r;
      out_now_r        <= clock_r;
      out_turnaround_r <= ta_r;
      out_waiting_r    <= fin_r ? ta_r - {16'h0000, fin_burst_r} : 32'd0;
      out_response_r   <= rt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      cnt_r        <= '0;
      cmp_vld_r    <= 1'b0;
      cmp_live_r   <= 1'b0;
      best_found_r <= 1'b0;
      free_found_r <= 1'b0;
      clock_r      <= '0;
      now_p1_r     <= 32'd1;
      out_valid_r  <= 1'b0;
    end else begin
      cmp_vld_r   <= cmd.rd_en;
      cmp_live_r  <= valid_r[cnt_r];
      out_valid_r <= cmd.report;
      if (cmd.load) begin
        cnt_r        <= '0;
        best_found_r <= 1'b0;
        free_found_r <= 1'b0;
      end else if (cmd.rd_en) begin
        cnt_r <= cnt_r + IDX_W'(1);
      end
      if (cmp_vld_r && cmp_live_r) best_found_r <= 1'b1;
      if (cmp_vld_r && !cmp_live_r) free_found_r <= 1'b1;
      if (cmd.update) begin
        if (op_r == OP_ARRIVE) begin
          if (free_found_r) valid_r[free_idx_r] <= 1'b1;
        end else begin
          clock_r  <= now_p1_r;
          now_p1_r <= now_p1_r + 32'd1;
          if (best_found_r && sel_fin) valid_r[best_idx_r] <= 1'b0;
        end
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_run_pid    = out_run_pid_r;
  assign out_finished   = out_finished_r;
  assign out_now        = out_now_r;
  assign out_turnaround = out_turnaround_r;
  assign out_waiting    = out_waiting_r;
  assign out_response   = out_response_r;

endmodule

@@ rtl/core/preemptive_priority_scheduler.sv @@
// Top level of the preemptive priority scheduler.
// Depends on ppsch_pkg, ppsch_ctrl and ppsch_dp.
//
//   Channel   Ports                                        Handshake
//   request   in_op, in_pid, in_burst, in_priority_req     start & !busy
//   result    out_kind, out_run_pid, out_finished,         out_valid, one cycle
//             out_now, out_turnaround, out_waiting,
//             out_response
//
// Each request is handled in order: it is latched on accept, then the table is
// read slot by slot through its single read port, followed by drain, update
// and report states; the result strobe is registered from the report state.
// Synchronous active-low reset empties the table and zeroes the clock at once.
// Results cannot be stalled; busy holds off requests while one is in flight.
module preemptive_priority_scheduler import ppsch_pkg::*; #(
  parameter int SLOTS    = 16,
  parameter int PID_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [7:0]  in_pid,
  input  logic [15:0] in_burst,
  input  logic [7:0]  in_priority_req,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_run_pid,
  output logic        out_finished,
  output logic [31:0] out_now,
  output logic [31:0] out_turnaround,
  output logic [31:0] out_waiting,
  output logic [31:0] out_response
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  ppsch_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  ppsch_dp #(
    .SLOTS    (SLOTS),
    .PID_BITS (PID_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_op           (in_op),
    .in_pid          (in_pid),
    .in_burst        (in_burst),
    .in_priority_req (in_priority_req),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_run_pid     (out_run_pid),
    .out_finished    (out_finished),
    .out_now         (out_now),
    .out_turnaround  (out_turnaround),
    .out_waiting     (out_waiting),
    .out_response    (out_response)
  );

  // The result strobe is a single-cycle pulse.
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // An accepted request keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("request accepted but block not busy");

  // Only a tick that ran a process may report completion.
  a_fin_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_finished) |-> (out_kind == KIND_RUN))
    else $error("completion reported on a non-run result");

  // Timing figures are zero unless a process completed.
  a_fin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_finished) |->
      (out_turnaround == 32'd0 && out_waiting == 32'd0 && out_response == 32'd0))
    else $error("timing figures nonzero without completion");

endmodule

@@ test/ppsch_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the preemptive priority scheduler: predicts every result
// from the accepted requests and compares it with the block's output.
// Depends on ppsch_pkg for the operation and result kind codes.
module ppsch_checker import ppsch_pkg::*; #(
  parameter int SLOTS    = 16,
  parameter int PID_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_op,
  input  logic [7:0]  in_pid,
  input  logic [15:0] in_burst,
  input  logic [7:0]  in_priority_req,
  input  logic        out_valid,
  input  logic [1:0]  out_kind,
  input  logic [7:0]  out_run_pid,
  input  logic        out_finished,
  input  logic [31:0] out_now,
  input  logic [31:0] out_turnaround,
  input  logic [31:0] out_waiting,
  input  logic [31:0] out_response,
  output int          mismatches,
  output int          pending
);

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  run_pid;
    logic        finished;
    logic [31:0] now;
    logic [31:0] turnaround;
    logic [31:0] waiting;
    logic [31:0] response;
  } sched_result_t;

  sched_result_t        sched_result_q[$];

  // Shadow copy of the ready table and the scheduler clock.
  logic                 slot_used    [SLOTS];
  logic [PID_BITS-1:0]  slot_pid     [SLOTS];
  logic [15:0]          slot_left    [SLOTS];
  logic [15:0]          slot_burst   [SLOTS];
  logic [7:0]           slot_prio    [SLOTS];
  logic [31:0]          slot_arrival [SLOTS];
  logic                 slot_started [SLOTS];
  logic [31:0]          slot_first   [SLOTS];
  logic [31:0]          sched_clock;

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  function automatic bit runs_before(int a, int b);
    if (slot_prio[a] != slot_prio[b])
      return slot_prio[a] < slot_prio[b];
    if (slot_left[a] != slot_left[b])
      return slot_left[a] < slot_left[b];
    if (slot_arrival[a] != slot_arrival[b])
      return slot_arrival[a] < slot_arrival[b];
    return slot_pid[a] <= slot_pid[b];
  endfunction

  // Applies one request to the shadow table and returns the result it causes.
  function automatic sched_result_t schedule_step(logic op, logic [7:0] pid,
                                                  logic [15:0] burst,
                                                  logic [7:0] prio);
    sched_result_t res;
    int pick;
    pick           = -1;
    res.kind       = KIND_IDLE;
    res.run_pid    = '0;
    res.finished   = 1'b0;
    res.turnaround = '0;
    res.waiting    = '0;
    res.response   = '0;
    if (op == OP_ARRIVE) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!slot_used[i] && pick < 0) pick = i;
      end
      res.run_pid = 8'(pid[PID_BITS-1:0]);
      if (pick < 0) begin
        res.kind = KIND_REJECT;
      end else begin
        res.kind            = KIND_ACCEPT;
        slot_used[pick]     = 1'b1;
        slot_pid[pick]      = pid[PID_BITS-1:0];
        slot_left[pick]     = burst;
        slot_burst[pick]    = burst;
        slot_prio[pick]     = prio;
        slot_arrival[pick]  = sched_clock;
        slot_started[pick]  = 1'b0;
        slot_first[pick]    = '0;
      end
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_used[i] && (pick < 0 || !runs_before(pick, i))) pick = i;
      end
      if (pick < 0) begin
        sched_clock = sched_clock + 32'd1;
      end else begin
        res.kind    = KIND_RUN;
        res.run_pid = 8'(slot_pid[pick]);
        if (!slot_started[pick]) begin
          slot_started[pick] = 1'b1;
          slot_first[pick]   = sched_clock;
        end
        sched_clock = sched_clock + 32'd1;
        // A zero burst finishes on its first tick just like a burst of one.
        if (slot_left[pick] <= 16'd1) begin
          slot_left[pick] = '0;
          slot_used[pick] = 1'b0;
          res.finished    = 1'b1;
          res.turnaround  = sched_clock - slot_arrival[pick];
          res.waiting     = res.turnaround - 32'(slot_burst[pick]);
          res.response    = slot_first[pick] - slot_arrival[pick];
        end else begin
          slot_left[pick] = slot_left[pick] - 16'd1;
        end
      end
    end
    res.now = sched_clock;
    return res;
  endfunction

  always @(posedge clk) begin
    sched_result_t seen;
    sched_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
      sched_clock = '0;
      sched_result_q.delete();
    end else begin
      if (out_valid) begin
        seen.kind       = out_kind;
        seen.run_pid    = out_run_pid;
        seen.finished   = out_finished;
        seen.now        = out_now;
        seen.turnaround = out_turnaround;
        seen.waiting    = out_waiting;
        seen.response   = out_response;
        if (sched_result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with no request outstanding: kind=%0d pid=%0d",
                     $realtime, seen.kind, seen.run_pid);
        end else begin
          want = sched_result_q.pop_front();
          if (seen.kind !== want.kind || seen.run_pid !== want.run_pid ||
              seen.finished !== want.finished || seen.now !== want.now ||
              seen.turnaround !== want.turnaround ||
              seen.waiting !== want.waiting || seen.response !== want.response) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch, expected kind=%0d pid=%0d fin=%0d now=%0d",
                       $realtime, want.kind, want.run_pid, want.finished, want.now);
              $display("    ta=%0d wt=%0d rt=%0d; got kind=%0d pid=%0d fin=%0d",
                       want.turnaround, want.waiting, want.response,
                       seen.kind, seen.run_pid, seen.finished);
              $display("    now=%0d ta=%0d wt=%0d rt=%0d", seen.now,
                       seen.turnaround, seen.waiting, seen.response);
            end
          end
        end
      end
      if (start && !busy)
        sched_result_q.push_back(schedule_step(in_op, in_pid, in_burst,
                                               in_priority_req));
    end
    pending = sched_result_q.size();
  end

endmodule

@@ test/preemptive_priority_scheduler_test.sv @@
`timescale 1ns / 100ps
// Top of the scheduler testbench: drives directed and random requests into
// the block and gives the verdict. Depends on ppsch_pkg and ppsch_checker.
module preemptive_priority_scheduler_test;
  import ppsch_pkg::*;

  localparam int SLOTS        = 16;
  localparam int PID_BITS     = 8;
  localparam int RANDOM_ITEMS = 1126;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_op;
  logic [7:0]  in_pid;
  logic [15:0] in_burst;
  logic [7:0]  in_priority_req;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [7:0]  out_run_pid;
  logic        out_finished;
  logic [31:0] out_now;
  logic [31:0] out_turnaround;
  logic [31:0] out_waiting;
  logic [31:0] out_response;
  int          mismatches;
  int          pending;
  bit          gaps_on;

  preemptive_priority_scheduler #(
    .SLOTS(SLOTS),
    .PID_BITS(PID_BITS)
  ) u_dut (.*);

  ppsch_checker #(
    .SLOTS(SLOTS),
    .PID_BITS(PID_BITS)
  ) u_checker (.*);

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_op           = OP_ARRIVE;
    in_pid          = '0;
    in_burst        = '0;
    in_priority_req = '0;
    gaps_on         = 1'b1;
  end

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the accept.
  task automatic send_request(input logic op, input logic [7:0] pid,
                              input logic [15:0] burst, input logic [7:0] prio);
    int gap;
    gap = gaps_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start           <= 1'b1;
    in_op           <= op;
    in_pid          <= pid;
    in_burst        <= burst;
    in_priority_req <= prio;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic send_tick();
    send_request(OP_TICK, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                 8'($urandom_range(0, 255)));
  endtask

  initial begin
    bit          fill_mode;
    bit          arrive;
    int          roll;
    int          big_left;
    logic [7:0]  pid;
    logic [7:0]  prio;
    logic [15:0] burst;
    big_left = 6;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: idle tick, extreme fields, zero burst, duplicate pids,
    // preemption by a better arrival, then a full table and a rejected request.
    send_tick();
    send_request(OP_ARRIVE, 8'd255, 16'd65535, 8'd255);
    send_request(OP_ARRIVE, 8'd0, 16'd0, 8'd0);
    send_tick();
    send_request(OP_ARRIVE, 8'd7, 16'd3, 8'd5);
    send_request(OP_ARRIVE, 8'd7, 16'd3, 8'd5);
    send_tick();
    send_request(OP_ARRIVE, 8'd9, 16'd1, 8'd0);
    send_tick();
    send_tick();
    for (int k = 0; k < SLOTS - 3; k++) send_request(OP_ARRIVE, 8'(16 + k), 16'd2, 8'd100);
    send_request(OP_ARRIVE, 8'd200, 16'd5, 8'd0);

    // Random: phases that fill the table and phases that drain it, chosen at random.
    fill_mode = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 30 == 0) fill_mode = 1'($urandom_range(0, 1));
      if (n % 60 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      arrive = ($urandom_range(0, 99) < (fill_mode ? 55 : 15));
      if (!arrive) begin
        send_tick();
      end else begin
        pid  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 7));
        prio = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 3));
        roll = $urandom_range(0, 99);
        if (roll < 85) begin
          burst = 16'($urandom_range(1, 6));
        end else if (roll < 97 || big_left == 0) begin
          burst = 16'($urandom_range(0, 40));
        end else begin
          // Long jobs get a poor priority so they cannot starve the table.
          big_left--;
          burst = 16'($urandom_range(0, 65535));
          prio  = 8'($urandom_range(200, 255));
        end
        send_request(OP_ARRIVE, pid, burst, prio);
      end
    end
    start <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (SLOTS + 8) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
